### rtl/apr_pkg.sv
// Shared types, constants and arithmetic helpers for the arc pose rollout block.
package apr_pkg;

  localparam int MAX_STEPS_DEF = 63;
  localparam int CORDIC_ITER_DEF = 16;

  localparam int TS_W = 16;
  localparam int SC_W = 6;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 1'b1;
  localparam logic [TS_W-1:0] TS_RESET = 16'd6554;
  localparam logic [SC_W-1:0] SC_RESET = 6'd10;

  localparam int CW = 34;  // CORDIC datapath width, Q2.30 plus headroom
  localparam int PW = 67;  // wide product width

  localparam longint GAIN_INF = 64'd652032874;
  localparam longint GAIN_CORR = 64'd434688583;
  localparam logic signed [31:0] QUARTER_PI_Q30 = 32'sd843314857;
  localparam logic signed [31:0] RAD_TO_BAM = 32'sd683565276;

  localparam int DIV_BITS = 29;
  localparam logic [DIV_BITS-1:0] DIV_ONE = 29'h1000_0000;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic div_start;
    logic cor_start;
    logic cor_sel;
    logic store0;
    logic store1;
    logic prod;
    logic upd;
    logic emit;
  } apr_cmd_t;

  typedef struct packed {
    logic straight;
    logic div_done;
    logic cor_done;
    logic last;
  } apr_sts_t;

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                               input int unsigned s);
    logic [PW-1:0] mag;
    logic neg;
    neg = v[PW-1];
    mag = neg ? PW'(-v) : PW'(v);
    mag = (mag + (PW'(1) << (s - 1))) >> s;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: return 34'sd843314857;
      5'd1: return 34'sd497837829;
      5'd2: return 34'sd263043837;
      5'd3: return 34'sd133525159;
      5'd4: return 34'sd67021687;
      5'd5: return 34'sd33543516;
      5'd6: return 34'sd16775851;
      5'd7: return 34'sd8388437;
      5'd8: return 34'sd4194283;
      5'd9: return 34'sd2097149;
      5'd10: return 34'sd1048576;
      5'd11: return 34'sd524288;
      5'd12: return 34'sd262144;
      5'd13: return 34'sd131072;
      5'd14: return 34'sd65536;
      5'd15: return 34'sd32768;
      5'd16: return 34'sd16384;
      5'd17: return 34'sd8192;
      5'd18: return 34'sd4096;
      5'd19: return 34'sd2048;
      5'd20: return 34'sd1024;
      5'd21: return 34'sd512;
      5'd22: return 34'sd256;
      5'd23: return 34'sd128;
      default: return '0;
    endcase
  endfunction

endpackage

### rtl/apr_if.sv
// Valid/ready channel interfaces for start items and trajectory poses.
interface apr_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic [15:0] start_heading;
  logic signed [15:0] speed;
  logic signed [15:0] curvature;
  modport source (output valid, start_x, start_y, start_heading, speed, curvature,
                  input ready);
  modport sink (input valid, start_x, start_y, start_heading, speed, curvature,
                output ready);
endinterface

interface apr_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [15:0] pose_heading;
  logic last_pose;
  modport source (output valid, pose_x, pose_y, pose_heading, last_pose, input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, last_pose, output ready);
endinterface

### rtl/arc_pose_rollout_top.sv
// Arc pose rollout: one start item in, start pose plus step_count arc or line poses out.
// The start pose follows the setup multiplies and, on an arc, the bit-serial radius divider as well.
// Each further pose takes one CORDIC run on a straight path and two on an arc, all on the single iterative CORDIC unit.
// One item at a time; the next is taken once its last pose sits in the output register.
// Asynchronous active-low reset returns to idle with time_step 6554 and step_count 10.
module arc_pose_rollout_top import apr_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  apr_in_if.sink               in_if,
  apr_out_if.source            out_if
);

  apr_cmd_t cmd;
  apr_sts_t sts;

  apr_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  apr_dp #(
    .MAX_STEPS         (MAX_STEPS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .start_x_i       (in_if.start_x),
    .start_y_i       (in_if.start_y),
    .start_heading_i (in_if.start_heading),
    .speed_i         (in_if.speed),
    .curvature_i     (in_if.curvature),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pose_x_o        (out_if.pose_x),
    .pose_y_o        (out_if.pose_y),
    .pose_heading_o  (out_if.pose_heading),
    .last_pose_o     (out_if.last_pose)
  );

endmodule

### rtl/apr_cordic.sv
// Iterative rotation-mode CORDIC giving cos and sin of a binary angle in Q2.30.
module apr_cordic import apr_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [15:0]          angle_i,
  output logic                 done_o,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  localparam int CNT_W = $clog2(CORDIC_ITERATIONS);
  localparam logic signed [CW-1:0] X_INIT =
    CW'(GAIN_INF + (GAIN_CORR >> (2 * CORDIC_ITERATIONS)));
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_ITERATIONS - 1);

  logic signed [CW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic run_q, run_d, done_q, done_d, flip_q, flip_d;
  logic signed [16:0] a_raw, a_fold;
  logic fold;
  logic signed [48:0] z_mul;
  logic signed [PW-1:0] z_rnd;
  logic signed [CW-1:0] sx, sy, at;

  always_comb begin
    a_raw = $signed({angle_i[15], angle_i});
    fold = 1'b0;
    a_fold = a_raw;
    if (a_raw > 17'sd16384) begin
      a_fold = a_raw - 17'sd32768;
      fold = 1'b1;
    end else if (a_raw < -17'sd16384) begin
      a_fold = a_raw + 17'sd32768;
      fold = 1'b1;
    end
    z_mul = a_fold * QUARTER_PI_Q30;
    z_rnd = rnd(PW'(z_mul), 13);
  end

  assign sx = x_q >>> cnt_q;
  assign sy = y_q >>> cnt_q;
  assign at = atan_q30(5'(cnt_q));

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    cnt_d = cnt_q;
    run_d = run_q;
    flip_d = flip_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d = X_INIT;
      y_d = '0;
      z_d = CW'(z_rnd);
      cnt_d = '0;
      run_d = 1'b1;
      flip_d = fold;
    end else if (run_q) begin
      if (!z_q[CW-1]) begin
        x_d = x_q - sy;
        y_d = y_q + sx;
        z_d = z_q - at;
      end else begin
        x_d = x_q + sy;
        y_d = y_q - sx;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    flip_q <= flip_d;
  end

  assign done_o = done_q;
  assign cos_o = flip_q ? -x_q : x_q;
  assign sin_o = flip_q ? -y_q : y_q;

endmodule

### rtl/apr_dp.sv
// Datapath: config registers, pose state, increment and radius math, step update.
module apr_dp import apr_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic signed [31:0]   start_x_i,
  input  logic signed [31:0]   start_y_i,
  input  logic [15:0]          start_heading_i,
  input  logic signed [15:0]   speed_i,
  input  logic signed [15:0]   curvature_i,
  input  apr_cmd_t             cmd_i,
  output apr_sts_t             sts_o,
  output logic signed [31:0]   pose_x_o,
  output logic signed [31:0]   pose_y_o,
  output logic [15:0]          pose_heading_o,
  output logic                 last_pose_o
);

  localparam int SW = $clog2(MAX_STEPS + 1);

  logic [TS_W-1:0] ts_q;
  logic [SC_W-1:0] sc_q;
  logic [SW-1:0] steps_q, steps_init;
  logic straight_q;
  logic signed [31:0] x_q, y_q, r_q;
  logic [15:0] h_q, inc_q;
  logic signed [15:0] v_q, k_q;
  logic signed [31:0] vk_q;
  logic signed [32:0] vdt_q;
  logic signed [33:0] qv_q;
  logic signed [CW-1:0] c0_q, s0_q, c1_q, s1_q;
  logic signed [PW-1:0] px_q, py_q;
  logic signed [31:0] pose_x_q, pose_y_q;
  logic [15:0] pose_h_q;
  logic last_q;

  logic div_run_q, div_done_q;
  logic [4:0] div_cnt_q;
  logic [DIV_BITS-1:0] dvd_q, quo_q;
  logic [15:0] rem_q, mag_q;
  logic [16:0] trial;
  logic [15:0] k_mag;

  logic signed [48:0] p_w;
  logic signed [PW-1:0] m_w, b_w, q_w, dx_w, dy_w;
  logic signed [34:0] opa, opx, opy;
  logic signed [TS_W:0] dt_s;

  logic cor_done;
  logic signed [CW-1:0] cor_c, cor_s;

  apr_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk_i,
    .rst_ni,
    .start_i (cmd_i.cor_start),
    .angle_i (cmd_i.cor_sel ? 16'(h_q + inc_q) : h_q),
    .done_o  (cor_done),
    .cos_o   (cor_c),
    .sin_o   (cor_s)
  );

  assign steps_init = (32'(sc_q) > MAX_STEPS) ? SW'(MAX_STEPS) : SW'(sc_q);
  assign dt_s = $signed({1'b0, ts_q});
  assign k_mag = k_q[15] ? 16'(-k_q) : 16'(k_q);
  assign trial = {rem_q, dvd_q[DIV_BITS-1]};

  always_comb begin
    p_w = vk_q * dt_s;
    q_w = rnd(PW'(p_w), 16);
    m_w = qv_q * RAD_TO_BAM;
    b_w = rnd(m_w, 36);
    opa = straight_q ? 35'(vdt_q) : 35'(r_q);
    opx = straight_q ? 35'(c0_q) : 35'(s1_q) - 35'(s0_q);
    opy = straight_q ? 35'(s0_q) : 35'(c1_q) - 35'(c0_q);
    dx_w = straight_q ? rnd(px_q, 38) : rnd(px_q, 30);
    dy_w = straight_q ? rnd(py_q, 38) : -rnd(py_q, 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TS_RESET;
      sc_q <= SC_RESET;
      steps_q <= '0;
      straight_q <= 1'b0;
      div_run_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TIME_STEP: ts_q <= cfg_data_i;
          CFG_STEP_COUNT: sc_q <= cfg_data_i[SC_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        steps_q <= steps_init;
        straight_q <= (curvature_i == 16'sd0);
      end else if (cmd_i.upd) begin
        steps_q <= steps_q - 1'b1;
      end
      div_done_q <= 1'b0;
      if (cmd_i.div_start) begin
        div_run_q <= 1'b1;
        div_cnt_q <= 5'(DIV_BITS - 1);
      end else if (div_run_q) begin
        div_cnt_q <= div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          div_run_q <= 1'b0;
          div_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= start_x_i;
      y_q <= start_y_i;
      h_q <= start_heading_i;
      v_q <= speed_i;
      k_q <= curvature_i;
      r_q <= '0;
    end
    if (cmd_i.mul1) begin
      vk_q <= v_q * k_q;
      vdt_q <= v_q * dt_s;
    end
    if (cmd_i.mul2) qv_q <= 34'(q_w);
    if (cmd_i.mul3) inc_q <= b_w[15:0];
    if (cmd_i.div_start) begin
      dvd_q <= DIV_ONE + DIV_BITS'(k_mag >> 1);
      rem_q <= '0;
      mag_q <= k_mag;
      quo_q <= '0;
    end else if (div_run_q) begin
      dvd_q <= dvd_q << 1;
      if (trial >= {1'b0, mag_q}) begin
        rem_q <= 16'(trial - {1'b0, mag_q});
        quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_q <= trial[15:0];
        quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
      end
    end
    if (div_done_q) r_q <= k_q[15] ? -32'($signed({1'b0, quo_q})) : 32'(quo_q);
    if (cmd_i.store0) begin
      c0_q <= cor_c;
      s0_q <= cor_s;
    end
    if (cmd_i.store1) begin
      c1_q <= cor_c;
      s1_q <= cor_s;
    end
    if (cmd_i.prod) begin
      px_q <= opa * opx;
      py_q <= opa * opy;
    end
    if (cmd_i.upd) begin
      x_q <= x_q + dx_w[31:0];
      y_q <= y_q + dy_w[31:0];
      if (!straight_q) h_q <= h_q + inc_q;
    end
    if (cmd_i.emit) begin
      pose_x_q <= x_q;
      pose_y_q <= y_q;
      pose_h_q <= h_q;
      last_q <= (steps_q == '0);
    end
  end

  assign sts_o.straight = straight_q;
  assign sts_o.div_done = div_done_q;
  assign sts_o.cor_done = cor_done;
  assign sts_o.last = (steps_q == '0);

  assign pose_x_o = pose_x_q;
  assign pose_y_o = pose_y_q;
  assign pose_heading_o = pose_h_q;
  assign last_pose_o = last_q;

endmodule

### rtl/apr_ctrl.sv
// Controller state machine sequencing setup, division, CORDIC runs and pose output.
module apr_ctrl import apr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  apr_sts_t sts_i,
  output apr_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_MUL3 = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_EMIT = 4'd5;
  localparam logic [3:0] S_COR0 = 4'd6;
  localparam logic [3:0] S_COR1 = 4'd7;
  localparam logic [3:0] S_PROD = 4'd8;
  localparam logic [3:0] S_UPD  = 4'd9;

  logic [3:0] state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = S_MUL3;
      end
      S_MUL3: begin
        cmd_o.mul3 = 1'b1;
        if (sts_i.straight) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.cor_start = 1'b1;
            state_d = S_COR0;
          end
        end
      end
      S_COR0: begin
        if (sts_i.cor_done) begin
          cmd_o.store0 = 1'b1;
          if (sts_i.straight) begin
            state_d = S_PROD;
          end else begin
            cmd_o.cor_start = 1'b1;
            cmd_o.cor_sel = 1'b1;
            state_d = S_COR1;
          end
        end
      end
      S_COR1: begin
        if (sts_i.cor_done) begin
          cmd_o.store1 = 1'b1;
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d = S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/apr_chk.sv
// Port-level checker for the arc pose rollout block and its bind.
module apr_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic last_pose,
  input logic [15:0] pose_heading
);

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted transaction did not make the block busy");

  a_mid_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !last_pose |-> !in_ready)
    else $error("input ready while a run is unfinished");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pose_heading) && $stable(last_pose))
    else $error("stalled pose changed");

  a_no_out_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("pose appeared too early after input transaction");

endmodule

bind arc_pose_rollout_top apr_chk u_apr_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .last_pose    (out_if.last_pose),
  .pose_heading (out_if.pose_heading)
);

### verif/testbench.sv
// Self-checking testbench for arc_pose_rollout_top: trajectory predictor plus random handshakes.
module testbench;
  import apr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        heading;
    logic signed [15:0] speed;
    logic signed [15:0] kappa;
  } start_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] heading;
    logic        last;
  } pose_t;

  localparam longint ATAN_TBL [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  apr_in_if  start_ch ();
  apr_out_if pose_ch ();

  arc_pose_rollout_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (start_ch),
    .out_if     (pose_ch)
  );

  logic [TS_W-1:0] dt_reg;
  logic [SC_W-1:0] steps_reg;
  pose_t pose_q[$];
  int mismatches;
  bit quiet;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic longint round_away(input longint v, input int s);
    longint mag;
    bit neg;
    neg = v < 0;
    mag = neg ? -v : v;
    mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return neg ? -mag : mag;
  endfunction

  function automatic void sin_cos(input logic [15:0] h, output longint c, output longint s);
    int a;
    bit flip;
    int n;
    longint x, y, z, t;
    a = int'($signed(h));
    flip = 1'b0;
    n = (CORDIC_ITER_DEF > 24) ? 24 : CORDIC_ITER_DEF;
    if (a > 16384) begin
      a -= 32768;
      flip = 1'b1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1'b1;
    end
    z = round_away(longint'(a) * longint'(QUARTER_PI_Q30), 13);
    x = GAIN_INF + (GAIN_CORR >> (2 * n));
    y = 0;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TBL[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TBL[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void predict_rollout(input start_t it);
    longint v, kap, dt, q, b, mag, radius, c0, s0, c1, s1, dx, dy;
    logic [15:0] incr, nh;
    int steps;
    pose_t p;
    v = longint'(it.speed);
    kap = longint'(it.kappa);
    dt = longint'(dt_reg);
    steps = (steps_reg > MAX_STEPS_DEF) ? MAX_STEPS_DEF : steps_reg;
    q = round_away(v * kap * dt, 16);
    b = round_away(q * longint'(RAD_TO_BAM), 36);
    incr = b[15:0];
    radius = 0;
    if (kap != 0) begin
      mag = (kap < 0) ? -kap : kap;
      radius = ((64'sd1 <<< 28) + mag / 2) / mag;
      if (kap < 0) radius = -radius;
    end
    p.x = it.x;
    p.y = it.y;
    p.heading = it.heading;
    p.last = (steps == 0);
    pose_q = {pose_q, p};
    while (steps > 0) begin
      sin_cos(p.heading, c0, s0);
      if (kap == 0) begin
        dx = round_away(v * c0 * dt, 38);
        dy = round_away(v * s0 * dt, 38);
      end else begin
        nh = p.heading + incr;
        sin_cos(nh, c1, s1);
        dx = round_away(radius * (s1 - s0), 30);
        dy = -round_away(radius * (c1 - c0), 30);
        p.heading = nh;
      end
      p.x = p.x + dx[31:0];
      p.y = p.y + dy[31:0];
      steps--;
      p.last = (steps == 0);
      pose_q = {pose_q, p};
    end
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_start(input start_t it);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      start_ch.valid <= 1'b0;
    end
    @(negedge clk);
    start_ch.valid <= 1'b1;
    start_ch.start_x <= it.x;
    start_ch.start_y <= it.y;
    start_ch.start_heading <= it.heading;
    start_ch.speed <= it.speed;
    start_ch.curvature <= it.kappa;
    do @(posedge clk); while (!start_ch.ready);
    predict_rollout(it);
  endtask

  // stop sending and let every pending pose drain
  task automatic drain_poses();
    @(negedge clk);
    start_ch.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain_poses();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIME_STEP) dt_reg = val[TS_W-1:0];
    else steps_reg = val[SC_W-1:0];
  endtask

  function automatic start_t random_start();
    start_t it;
    it.x = $urandom();
    it.y = $urandom();
    it.heading = 16'($urandom());
    it.speed = 16'($urandom());
    case ($urandom_range(0, 3))
      0: it.kappa = '0;
      1: it.kappa = $signed(16'($urandom_range(0, 64))) - 16'sd32;
      default: it.kappa = 16'($urandom());
    endcase
    return it;
  endfunction

  // result side: random stalls, one check per transaction
  initial begin
    int gap;
    pose_ch.ready = 1'b0;
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        @(negedge clk);
        pose_ch.ready <= 1'b0;
      end
      @(negedge clk);
      pose_ch.ready <= 1'b1;
      do @(posedge clk); while (!pose_ch.valid);
    end
  end

  always @(posedge clk) begin
    pose_t want;
    pose_t got;
    if (rst_n && pose_ch.valid && pose_ch.ready) begin
      got = {pose_ch.pose_x, pose_ch.pose_y, pose_ch.pose_heading, pose_ch.last_pose};
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose x=%h y=%h h=%h last=%b",
                                       got.x, got.y, got.heading, got.last);
      end else begin
        want = pose_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch exp x=%h y=%h h=%h last=%b got x=%h y=%h h=%h last=%b",
                     want.x, want.y, want.heading, want.last,
                     got.x, got.y, got.heading, got.last);
        end
      end
    end
  end

  task automatic test_directed();
    start_t it;
    for (int k = 0; k < 16; k++) begin
      it = '{x: 0, y: 0, heading: 0, speed: 16'sd256, kappa: 0};
      case (k)
        1: it = '{x: 32'sh7fffffff, y: 32'sh80000000, heading: 16'hffff,
                  speed: 16'sh8000, kappa: 16'sh8000};
        2: it = '{x: 32'sh80000000, y: 32'sh7fffffff, heading: 16'h0000,
                  speed: 16'sh7fff, kappa: 16'sh7fff};
        3: it.kappa = 16'sd1;
        4: it.kappa = -16'sd1;
        5: it = '{x: 32'sd65536, y: -32'sd65536, heading: 16'd4096, speed: 0, kappa: 16'sd4096};
        6: it.heading = 16'd16384;
        7: it.heading = 16'd16385;
        8: it.heading = 16'd32768;
        9: it.heading = 16'd49151;
        10: it = '{x: 0, y: 0, heading: 16'd49152, speed: 16'sh7fff, kappa: 0};
        11: it = '{x: 32'sh7fff0000, y: 0, heading: 0, speed: 16'sh7fff, kappa: 0};
        12: it = '{x: 0, y: 0, heading: 16'd8192, speed: -16'sd512, kappa: -16'sd4096};
        13: it = '{x: 0, y: 0, heading: 16'd60000, speed: 0, kappa: 0};
        14: it = '{x: 32'sh12345678, y: 32'shedcba987, heading: 16'h5a5a,
                   speed: 16'sh7fff, kappa: 16'sh7fff};
        15: it = random_start();
        default: ;
      endcase
      send_start(it);
    end
  endtask

  task automatic test_zero_steps();
    write_reg(CFG_STEP_COUNT, '0);
    write_reg(CFG_TIME_STEP, 16'hffff);
    repeat (4) send_start(random_start());
  endtask

  task automatic test_max_steps();
    write_reg(CFG_STEP_COUNT, CFG_W'(63));
    send_start('{x: 0, y: 0, heading: 16'd100, speed: 16'sh7fff, kappa: 16'sh7fff});
    send_start('{x: 0, y: 0, heading: 16'd40000, speed: 16'sh8000, kappa: 0});
    send_start(random_start());
    write_reg(CFG_TIME_STEP, 16'd1);
    send_start(random_start());
  endtask

  task automatic test_zero_dt();
    write_reg(CFG_TIME_STEP, '0);
    write_reg(CFG_STEP_COUNT, CFG_W'(5));
    send_start('{x: 32'sd7, y: -32'sd7, heading: 16'd3000, speed: 16'sh7fff, kappa: 16'sd77});
    send_start('{x: 32'sd9, y: 32'sd9, heading: 16'd3000, speed: 16'sh8000, kappa: 0});
  endtask

  task automatic test_random();
    int sc;
    int ts;
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 4))
        0: ts = 1;
        1: ts = 65535;
        default: ts = $urandom_range(1, 65535);
      endcase
      sc = ($urandom_range(0, 9) == 0) ? 63 : $urandom_range(0, 8);
      write_reg(CFG_TIME_STEP, CFG_W'(ts));
      write_reg(CFG_STEP_COUNT, CFG_W'(sc));
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ((sc == 63) ? 4 : 29); n++) begin
        send_start(random_start());
        if (n == 10) drain_poses();
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    start_ch.valid = 1'b0;
    start_ch.start_x = '0;
    start_ch.start_y = '0;
    start_ch.start_heading = '0;
    start_ch.speed = '0;
    start_ch.curvature = '0;
    dt_reg = TS_RESET;
    steps_reg = SC_RESET;
    mismatches = 0;
    quiet = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_zero_steps();
    test_max_steps();
    test_zero_dt();
    test_random();

    drain_poses();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/apr_pkg.sv
rtl/apr_if.sv
rtl/apr_cordic.sv
rtl/apr_dp.sv
rtl/apr_ctrl.sv
rtl/arc_pose_rollout_top.sv
rtl/apr_chk.sv
verif/testbench.sv
